// ===== rtl/bpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpsc_pkg: shared types and constants for the pattern syntax checker
// Byte codes, scan modes and the scanner state record.
// ----------------------------------------------------------------------------
package bpsc_pkg;

    localparam int unsigned MAX_GROUPS = 9;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned MODE_W     = 3;

    // Scan modes
    localparam logic [MODE_W-1:0] MODE_NORMAL      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ESCAPE      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLASS_START = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLASS_CARET = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLASS_BODY  = 3'd4;

    // Byte codes
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_CARET  = 8'h5E;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [CNT_W-1:0] GROUP_LIMIT = CNT_W'(MAX_GROUPS);

    typedef struct packed {
        logic [MODE_W-1:0] scan_mode;
        logic [CNT_W-1:0]  open_count;
        logic [CNT_W-1:0]  closed_count;
        logic [CNT_W-1:0]  opened_total;
        logic              just_closed;
        logic              error_seen;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        scan_mode:    MODE_NORMAL,
        open_count:   '0,
        closed_count: '0,
        opened_total: '0,
        just_closed:  1'b0,
        error_seen:   1'b0
    };

endpackage

// ===== rtl/bpsc_scan.sv =====
// ----------------------------------------------------------------------------
// bpsc_scan: per-byte scanner step
// Next scanner state from the current state and one pattern byte.
// ----------------------------------------------------------------------------
module bpsc_scan import bpsc_pkg::*; (
    input  scan_state_t cur_state,
    input  logic [7:0]  pattern_byte,
    output scan_state_t nxt_state
);

    logic [CNT_W-1:0] digit_val;

    // '1'..'9' carry their value in the low nibble
    assign digit_val = pattern_byte[CNT_W-1:0];

    always_comb begin
        nxt_state = cur_state;
        if (!cur_state.error_seen) begin
            case (cur_state.scan_mode)
                MODE_ESCAPE: begin
                    nxt_state.scan_mode = MODE_NORMAL;
                    if (pattern_byte == CHAR_LPAREN) begin
                        if (cur_state.opened_total >= GROUP_LIMIT) begin
                            nxt_state.error_seen = 1'b1;
                        end else begin
                            nxt_state.opened_total = cur_state.opened_total + 1'b1;
                            nxt_state.open_count   = cur_state.open_count + 1'b1;
                            nxt_state.just_closed  = 1'b0;
                        end
                    end else if (pattern_byte == CHAR_RPAREN) begin
                        if (cur_state.open_count == '0) begin
                            nxt_state.error_seen = 1'b1;
                        end else begin
                            nxt_state.open_count   = cur_state.open_count - 1'b1;
                            nxt_state.closed_count = cur_state.closed_count + 1'b1;
                            nxt_state.just_closed  = 1'b1;
                        end
                    end else if (pattern_byte inside {[CHAR_ONE:CHAR_NINE]}) begin
                        if (digit_val > cur_state.closed_count) begin
                            nxt_state.error_seen = 1'b1;
                        end else begin
                            nxt_state.just_closed = 1'b0;
                        end
                    end else begin
                        nxt_state.just_closed = 1'b0;
                    end
                end
                MODE_CLASS_START: begin
                    nxt_state.scan_mode = (pattern_byte == CHAR_CARET) ?
                                          MODE_CLASS_CARET : MODE_CLASS_BODY;
                end
                MODE_CLASS_CARET: begin
                    nxt_state.scan_mode = MODE_CLASS_BODY;
                end
                MODE_CLASS_BODY: begin
                    if (pattern_byte == CHAR_RBRACK) begin
                        nxt_state.scan_mode = MODE_NORMAL;
                    end
                end
                MODE_NORMAL: begin
                    if (pattern_byte == CHAR_BSLASH) begin
                        nxt_state.scan_mode = MODE_ESCAPE;
                    end else if (pattern_byte == CHAR_LBRACK) begin
                        nxt_state.scan_mode   = MODE_CLASS_START;
                        nxt_state.just_closed = 1'b0;
                    end else if (pattern_byte == CHAR_STAR) begin
                        // star keeps just_closed, so a second star also fails
                        if (cur_state.just_closed) begin
                            nxt_state.error_seen = 1'b1;
                        end
                    end else begin
                        nxt_state.just_closed = 1'b0;
                    end
                end
                default: begin
                    nxt_state.scan_mode = MODE_NORMAL;
                end
            endcase
        end
    end

endmodule

// ===== rtl/bpsc_verdict.sv =====
// ----------------------------------------------------------------------------
// bpsc_verdict: end-of-pattern check
// Judges a finished pattern from the scanner state after its final byte.
// ----------------------------------------------------------------------------
module bpsc_verdict import bpsc_pkg::*; (
    input  scan_state_t end_state,
    output logic        pattern_ok
);

    // open escape, open class or open group all fail
    assign pattern_ok = !end_state.error_seen
                        && (end_state.scan_mode == MODE_NORMAL)
                        && (end_state.open_count == '0);

endmodule

// ===== rtl/bre_pattern_syntax_check.sv =====
// ----------------------------------------------------------------------------
// bre_pattern_syntax_check: streaming syntax check for basic regular expressions
// Scans pattern bytes one per request and reports one verdict per pattern.
// ----------------------------------------------------------------------------
// Feed the pattern one byte per request on s_tdata, with s_tlast high on its
// final byte. Non-final bytes produce nothing; the final byte produces one
// result request whose m_tdata[0] is 1 for a well-formed pattern and 0 for a
// malformed one (dangling backslash, more than MAX_GROUPS escaped group opens,
// unmatched escaped close, back-reference above the groups closed so far,
// unclosed bracket class, star right after a group close, or a group left
// open). The scanner state is cleared after every verdict, so the next byte
// starts a new pattern. The scanner registers are updated through one level
// of compare-and-count logic at the accepting edge, and the verdict lands in
// the output register at that same edge, so it is valid in the cycle after
// the final byte is taken. s_tready stays high unless a verdict is held
// waiting on m_tready, so with a ready consumer one byte is taken every
// cycle. There is no reset sweep; the block is ready right after aresetn
// deasserts.
// ----------------------------------------------------------------------------
module bre_pattern_syntax_check import bpsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] pattern_byte
    input  logic       s_tlast,   // last_byte
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] pattern_ok, [7:1] zero
);

    scan_state_t scan_reg;
    scan_state_t scan_next;
    scan_state_t step_state;

    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic        ok_reg;
    logic        ok_next;
    logic        step_ok;
    logic        s_accept;

    // Hold input only while a verdict is stuck at the output.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    bpsc_scan u_scan (
        .cur_state    (scan_reg),
        .pattern_byte (s_tdata),
        .nxt_state    (step_state)
    );

    // Verdict is judged on the state after the final byte is applied.
    bpsc_verdict u_verdict (
        .end_state  (step_state),
        .pattern_ok (step_ok)
    );

    always_comb begin
        scan_next     = scan_reg;
        m_tvalid_next = m_tvalid_reg;
        ok_next       = ok_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (s_accept) begin
            if (s_tlast) begin
                // final byte: emit verdict, restart for the next pattern
                scan_next     = SCAN_RESET;
                m_tvalid_next = 1'b1;
                ok_next       = step_ok;
            end else begin
                scan_next = step_state;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg     <= SCAN_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            scan_reg     <= scan_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        ok_reg <= ok_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, ok_reg};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bre_pattern_syntax_check
// Streams regex patterns byte by byte and checks every verdict against a
// cycle-free scanner model kept in the bench, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import bpsc_pkg::*;

    // Cycles with no request moving on either channel before we give up.
    localparam int WATCHDOG_LIMIT = 4000;
    // Leave some margin at the end after the last verdict is taken.
    localparam int DRAIN_TAIL     = 8;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] pattern_byte
    logic       s_tlast  = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] pattern_ok, [7:1] zero

    // Percent chance per cycle that the sender idles / the receiver stalls.
    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;

    // Scanner state mirrored from the accepted byte stream.
    scan_state_t scan = SCAN_RESET;
    // Verdicts predicted but not yet seen on the result channel.
    logic        verdict_q[$];
    logic        want_ok;
    int unsigned bad_verdicts = 0;
    int unsigned idle_cycles  = 0;

    always #6 aclk = ~aclk;

    bre_pattern_syntax_check u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // Scanner model: advance the mirrored state by one pattern byte.
    // Only called while no error is latched; errors freeze everything.
    // ------------------------------------------------------------------
    function automatic void scan_pattern_byte(input logic [7:0] c);
        int ref_num;
        case (scan.scan_mode)
            MODE_ESCAPE: begin
                scan.scan_mode = MODE_NORMAL;
                if (c == CHAR_LPAREN) begin
                    // open beyond the group limit: error, counters frozen
                    if (int'(scan.opened_total) >= MAX_GROUPS) begin
                        scan.error_seen = 1'b1;
                    end else begin
                        scan.opened_total = scan.opened_total + 1'b1;
                        scan.open_count   = scan.open_count + 1'b1;
                        scan.just_closed  = 1'b0;
                    end
                end else if (c == CHAR_RPAREN) begin
                    if (scan.open_count == '0) begin
                        scan.error_seen = 1'b1;
                    end else begin
                        scan.open_count   = scan.open_count - 1'b1;
                        scan.closed_count = scan.closed_count + 1'b1;
                        scan.just_closed  = 1'b1;
                    end
                end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
                    // back-reference may only name a group already closed
                    ref_num = int'(c - CHAR_ONE) + 1;
                    if (ref_num > int'(scan.closed_count))
                        scan.error_seen = 1'b1;
                    else
                        scan.just_closed = 1'b0;
                end else begin
                    scan.just_closed = 1'b0;
                end
            end
            MODE_CLASS_START: begin
                // caret right after '[' negates; anything else is class body
                scan.scan_mode = (c == CHAR_CARET) ? MODE_CLASS_CARET : MODE_CLASS_BODY;
            end
            MODE_CLASS_CARET: begin
                // even ']' here is a literal
                scan.scan_mode = MODE_CLASS_BODY;
            end
            MODE_CLASS_BODY: begin
                if (c == CHAR_RBRACK)
                    scan.scan_mode = MODE_NORMAL;
            end
            MODE_NORMAL: begin
                if (c == CHAR_BSLASH) begin
                    scan.scan_mode = MODE_ESCAPE;
                end else if (c == CHAR_LBRACK) begin
                    scan.scan_mode   = MODE_CLASS_START;
                    scan.just_closed = 1'b0;
                end else if (c == CHAR_STAR) begin
                    // star keeps just_closed, so a run of stars after a close fails
                    if (scan.just_closed)
                        scan.error_seen = 1'b1;
                end else begin
                    scan.just_closed = 1'b0;
                end
            end
            default: scan.scan_mode = MODE_NORMAL;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Send one pattern byte; returns at the edge where the request is taken.
    // s_tvalid is left high so back-to-back bytes follow without a gap.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // request accepted at this edge: update the model
        if (!scan.error_seen)
            scan_pattern_byte(b);
        if (last) begin
            verdict_q.push_back(!scan.error_seen && scan.scan_mode == MODE_NORMAL &&
                                scan.open_count == '0);
            scan = SCAN_RESET;
        end
    endtask

    // Whole pattern from a string; the final character carries tlast.
    task automatic send_text(input string p);
        for (int i = 0; i < p.len(); i++)
            send_byte(p[i], i == p.len() - 1);
    endtask

    // Sender holds off until every predicted verdict has been taken.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Random pattern builder. Mostly token-structured so groups, classes
    // and back-references nest and close; some raw noise bytes mixed in.
    // ------------------------------------------------------------------
    task automatic send_random_pattern(output int unsigned nbytes);
        logic [7:0]  pat[$];
        int unsigned n_tok;
        int unsigned kind;
        int unsigned depth;
        int unsigned opened;
        int unsigned closed;
        int unsigned digit;
        n_tok  = $urandom_range(1, 12);
        depth  = 0;
        opened = 0;
        closed = 0;
        for (int t = 0; t < n_tok; t++) begin
            kind = $urandom_range(99);
            if (kind < 28) begin
                pat.push_back(8'($urandom_range(255)));
            end else if (kind < 38) begin
                pat.push_back(CHAR_STAR);
            end else if (kind < 52) begin
                if (opened < MAX_GROUPS || $urandom_range(9) == 0) begin
                    pat.push_back(CHAR_BSLASH);
                    pat.push_back(CHAR_LPAREN);
                    depth++;
                    opened++;
                end
            end else if (kind < 66) begin
                if (depth > 0 || $urandom_range(9) == 0) begin
                    pat.push_back(CHAR_BSLASH);
                    pat.push_back(CHAR_RPAREN);
                    if (depth > 0) begin
                        depth--;
                        closed++;
                    end
                end
            end else if (kind < 74) begin
                // back-reference: usually legal, sometimes any digit
                if (closed > 0 && $urandom_range(4) != 0)
                    digit = $urandom_range(1, (closed > 9) ? 9 : closed);
                else
                    digit = $urandom_range(1, 9);
                pat.push_back(CHAR_BSLASH);
                pat.push_back(CHAR_ONE + 8'(digit - 1));
            end else if (kind < 88) begin
                pat.push_back(CHAR_LBRACK);
                if ($urandom_range(2) == 0) pat.push_back(CHAR_CARET);
                if ($urandom_range(2) == 0) pat.push_back(CHAR_RBRACK);
                repeat ($urandom_range(3)) pat.push_back(8'($urandom_range(255)));
                if ($urandom_range(9) != 0) pat.push_back(CHAR_RBRACK);
            end else if (kind < 95) begin
                pat.push_back(CHAR_BSLASH);
                pat.push_back(8'($urandom_range(255)));
            end else begin
                // stray structural byte, e.g. dangling backslash at the end
                case ($urandom_range(3))
                    0: pat.push_back(CHAR_BSLASH);
                    1: pat.push_back(CHAR_LBRACK);
                    2: pat.push_back(CHAR_RBRACK);
                    default: pat.push_back(CHAR_CARET);
                endcase
            end
        end
        // close what is still open, most of the time
        while (depth > 0 && $urandom_range(99) < 85) begin
            pat.push_back(CHAR_BSLASH);
            pat.push_back(CHAR_RPAREN);
            depth--;
        end
        if (pat.size() == 0)
            pat.push_back(8'($urandom_range(255)));
        for (int i = 0; i < pat.size(); i++)
            send_byte(pat[i], i == pat.size() - 1);
        nbytes = pat.size();
    endtask

    task automatic run_random_stream(input int unsigned byte_budget);
        int unsigned sent;
        int unsigned n;
        sent = 0;
        while (sent < byte_budget) begin
            send_random_pattern(n);
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        send_byte(8'h00, 1'b1);          // lowest byte, single-byte pattern
        send_byte(8'hFF, 1'b1);          // highest byte
        send_text("\\");                 // dangling backslash
        send_text("[a");                 // unclosed class
        send_text("[^]]");               // caret then literal close bracket
        send_text("[]]*");               // leading close bracket is literal
        send_text("\\)");                // close with nothing open
        send_text("\\(");                // group left open
        send_text("\\(\\)*");            // star after group close
        send_text("\\(a\\)\\1");         // legal back-reference
        send_text("\\(\\)\\2");          // back-reference past closed groups
        send_text("a**");                // stars without a close are fine
        send_text("\\)\\(\\)");          // error sticks, later bytes ignored
        send_text("\\(\\(\\)\\)\\2");    // nested groups
    endtask

    task automatic test_group_limit();
        // exactly the limit: legal, and the top back-reference digit works
        for (int i = 0; i < MAX_GROUPS; i++) begin
            send_byte(CHAR_BSLASH, 1'b0);
            send_byte(CHAR_LPAREN, 1'b0);
        end
        for (int i = 0; i < MAX_GROUPS; i++) begin
            send_byte(CHAR_BSLASH, 1'b0);
            send_byte(CHAR_RPAREN, 1'b0);
        end
        send_byte(CHAR_BSLASH, 1'b0);
        send_byte(CHAR_NINE, 1'b1);
        // one open too many
        for (int i = 0; i <= MAX_GROUPS; i++) begin
            send_byte(CHAR_BSLASH, 1'b0);
            send_byte(CHAR_LPAREN, 1'b0);
        end
        send_byte(CHAR_BSLASH, 1'b0);
        send_byte(CHAR_RPAREN, 1'b1);
    endtask

    task automatic test_stream_no_idle();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_random_stream(140);
    endtask

    task automatic test_stream_sender_idle();
        src_idle_pct  = 80;
        snk_stall_pct = 0;
        run_random_stream(140);
        hold_until_drained();
    endtask

    task automatic test_stream_receiver_stall();
        src_idle_pct  = 0;
        snk_stall_pct = 80;
        run_random_stream(140);
    endtask

    task automatic test_stream_both_idle();
        src_idle_pct  = 9;
        snk_stall_pct = 9;
        run_random_stream(140);
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and verdict checking.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected verdict request: pattern_ok=%0b", m_tdata[0]);
                bad_verdicts++;
            end else begin
                want_ok = verdict_q.pop_front();
                if (m_tdata[0] !== want_ok) begin
                    $error("pattern_ok: expected %0b, got %0b", want_ok, m_tdata[0]);
                    bad_verdicts++;
                end
                if (m_tdata[7:1] !== 7'd0) begin
                    $error("m_tdata pad: expected %0h, got %0h", 7'd0, m_tdata[7:1]);
                    bad_verdicts++;
                end
            end
        end
    end

    // Watchdog: no request moving on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_group_limit();
        test_stream_no_idle();
        test_stream_sender_idle();
        test_stream_receiver_stall();
        test_stream_both_idle();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (bad_verdicts == 0 && verdict_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
